FILE: hdl/quadtree_image_encoder_unit_assert.svh
// Assertion macros for the quadtree image encoder.
`ifndef QUADTREE_IMAGE_ENCODER_UNIT_ASSERT_SVH
`define QUADTREE_IMAGE_ENCODER_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define QIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define QIE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hdl/qie_pkg.sv
// Package: constants, types and commands for the quadtree image encoder.
package qie_pkg;
    localparam int MaxSide    = 512;
    localparam int ColorBits  = 10;
    localparam int SideW      = $clog2(MaxSide + 1);
    localparam int CoordW     = $clog2(MaxSide);
    localparam int AddrW      = 2 * CoordW;
    localparam int StackDepth = 64;
    localparam int SpW        = $clog2(StackDepth + 1);
    localparam int SpIdxW     = $clog2(StackDepth);
    localparam int CfgW       = 10;

    localparam logic [0:0] OpLoad    = 1'b0;
    localparam logic [0:0] OpRequest = 1'b1;
    localparam logic [0:0] RegWidth  = 1'b0;
    localparam logic [0:0] RegHeight = 1'b1;

    typedef struct packed {
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic [SideW-1:0]  w;
        logic [SideW-1:0]  h;
    } t_region;

    // controller -> datapath
    typedef struct packed {
        logic load_wr;     // store a pixel
        logic load_clr;    // restart load count
        logic sp_clr;      // empty the stack
        logic push_root;   // push whole image
        logic pop;         // pop region into working regs
        logic rd_issue;    // issue a pixel read for scan
        logic scan_init;   // start scan (first pixel is reference)
        logic split;       // push up to four quadrants (one per cycle)
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic stack_empty;
        logic scan_last;   // current issued read is last of region
        logic mismatch;    // registered compare result, or the compare on the current read
        logic split_done;
    } t_sts;
endpackage

FILE: hdl/qie_datapath.sv
// Datapath: pixel memory, region stack, scan counters and quadrant pushes.
module qie_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  qie_pkg::t_cmd                   i_cmd,
    input  logic [15:0]                     i_pixel,
    input  logic [qie_pkg::SideW-1:0]       i_w_img,
    input  logic [qie_pkg::SideW-1:0]       i_h_img,
    input  logic                            i_rd_vld,
    output qie_pkg::t_sts                   o_sts,
    output logic [qie_pkg::ColorBits-1:0]   o_ref_color
);
    localparam int Depth = qie_pkg::MaxSide * qie_pkg::MaxSide;
    localparam int LcW   = qie_pkg::AddrW + 1;

    logic [qie_pkg::ColorBits-1:0] r_mem [Depth];
    logic [qie_pkg::ColorBits-1:0] r_rdata;
    qie_pkg::t_region              r_stack [qie_pkg::StackDepth];
    qie_pkg::t_region              r_top;
    logic [qie_pkg::SpW-1:0]       r_sp;
    logic [LcW-1:0]                r_lc;
    qie_pkg::t_region              r_reg;
    logic [qie_pkg::SideW-1:0]     r_i, r_j;
    logic [qie_pkg::AddrW-1:0]     r_row_base;
    logic [qie_pkg::ColorBits-1:0] r_ref;
    logic                          r_mis;
    logic [1:0]                    r_qi;
    logic                          r_first;

    logic [2*qie_pkg::SideW-1:0]   limit;
    logic [LcW-1:0]                lc_eff;
    logic                          lc_ok;
    logic [qie_pkg::AddrW-1:0]     rd_addr;
    logic [qie_pkg::SideW-1:0]     hw, hh, lw, lh;
    qie_pkg::t_region              quad;
    logic                          do_push;
    qie_pkg::t_region              push_val;
    logic [qie_pkg::SpIdxW-1:0]    push_idx;

    assign limit   = i_w_img * i_h_img;
    // a restart stores this pixel at entry 0
    assign lc_eff  = i_cmd.load_clr ? '0 : r_lc;
    assign lc_ok   = i_cmd.load_wr && ((2*qie_pkg::SideW)'(lc_eff) < limit)
                     && (lc_eff < LcW'(Depth));
    assign rd_addr = r_row_base + qie_pkg::AddrW'(r_reg.x) + qie_pkg::AddrW'(r_j);
    assign lw = r_reg.w >> 1;
    assign lh = r_reg.h >> 1;
    assign hw = r_reg.w - lw;
    assign hh = r_reg.h - lh;

    always_comb begin
        quad = r_reg;
        case (r_qi)
            2'd0: quad = '{x: r_reg.x + qie_pkg::CoordW'(hw),
                           y: r_reg.y + qie_pkg::CoordW'(hh), w: lw, h: lh};
            2'd1: quad = '{x: r_reg.x, y: r_reg.y + qie_pkg::CoordW'(hh), w: hw, h: lh};
            2'd2: quad = '{x: r_reg.x + qie_pkg::CoordW'(hw), y: r_reg.y, w: lw, h: hh};
            default: quad = '{x: r_reg.x, y: r_reg.y, w: hw, h: hh};
        endcase
    end

    always_comb begin
        push_val = quad;
        do_push  = 1'b0;
        if (i_cmd.push_root) begin
            push_val = '{x: '0, y: '0, w: i_w_img, h: i_h_img};
            do_push  = 1'b1;
        end else if (i_cmd.split) begin
            do_push = (quad.w != '0) && (quad.h != '0);
        end
        push_idx = r_sp[qie_pkg::SpIdxW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (lc_ok)
            r_mem[lc_eff[qie_pkg::AddrW-1:0]] <= i_pixel[qie_pkg::ColorBits-1:0];
        if (i_cmd.rd_issue)
            r_rdata <= r_mem[rd_addr];
        if (do_push && r_sp < qie_pkg::SpW'(qie_pkg::StackDepth))
            r_stack[push_idx] <= push_val;
        r_top <= r_stack[qie_pkg::SpIdxW'(r_sp - 1'b1)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
            r_lc <= '0;
            r_mis <= 1'b0;
            r_qi <= '0;
            r_first <= 1'b0;
        end else begin
            if (lc_ok) r_lc <= lc_eff + 1'b1;
            else if (i_cmd.load_clr) r_lc <= '0;
            if (i_cmd.sp_clr) r_sp <= '0;
            else if (i_cmd.pop) r_sp <= r_sp - 1'b1;
            else if (do_push && r_sp < qie_pkg::SpW'(qie_pkg::StackDepth))
                r_sp <= r_sp + 1'b1;
            if (i_cmd.split) r_qi <= r_qi + 1'b1;
            else r_qi <= '0;
            if (i_cmd.scan_init) begin
                r_mis   <= 1'b0;
                r_first <= 1'b1;
            end else if (i_rd_vld) begin
                r_first <= 1'b0;
                if (!r_first && r_rdata != r_ref) r_mis <= 1'b1;
            end
        end
    end

    // scan position and reference colour (payload)
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop) r_reg <= r_top;
        if (i_rd_vld && r_first) r_ref <= r_rdata;
        if (i_cmd.scan_init) begin
            r_i <= '0;
            r_j <= '0;
            r_row_base <= qie_pkg::AddrW'(r_reg.y) * qie_pkg::AddrW'(i_w_img);
        end else if (i_cmd.rd_issue) begin
            if (r_j == r_reg.w - 1'b1) begin
                r_j <= '0;
                r_i <= r_i + 1'b1;
                r_row_base <= r_row_base + qie_pkg::AddrW'(i_w_img);
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end

    assign o_sts.stack_empty = (r_sp == '0);
    assign o_sts.scan_last   = (r_j == r_reg.w - 1'b1) && (r_i == r_reg.h - 1'b1);
    assign o_sts.mismatch    = r_mis || (i_rd_vld && !r_first && r_rdata != r_ref);
    assign o_sts.split_done  = (r_qi == 2'd3);
    assign o_ref_color       = (i_rd_vld && r_first) ? r_rdata : r_ref;
endmodule

FILE: hdl/qie_ctrl.sv
// Controller: sequences load, pop, scan, split and token output.
module qie_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_fire,
    input  logic                          i_op,
    input  qie_pkg::t_sts                 i_sts,
    input  logic                          i_out_free,
    output logic                          o_in_ready,
    output qie_pkg::t_cmd                 o_cmd,
    output logic                          o_rd_vld,
    output logic                          o_tok_load,
    output logic                          o_tok_leaf
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_POP   = 7'b0000010,
        S_LATCH = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_DRAIN = 7'b0010000,
        S_SPLIT = 7'b0100000,
        S_TOP   = 7'b1000000
    } t_state;

    typedef enum logic [2:0] {
        P_LOAD = 3'b001,
        P_ENC  = 3'b010,
        P_DONE = 3'b100
    } t_phase;

    t_state r_st, n_st;
    t_phase r_ph, n_ph;
    logic   r_rdv, n_rdv;
    logic   r_leaf, n_leaf;

    assign o_in_ready = (r_st == S_IDLE) && i_out_free;
    assign o_rd_vld   = r_rdv;

    always_comb begin
        n_st = r_st;
        n_ph = r_ph;
        n_rdv = 1'b0;
        n_leaf = r_leaf;
        o_cmd = '0;
        o_tok_load = 1'b0;
        o_tok_leaf = r_leaf;
        unique case (r_st)
            S_IDLE: begin
                if (i_in_fire) begin
                    if (i_op == qie_pkg::OpLoad) begin
                        o_cmd.load_wr = 1'b1;
                        if (r_ph != P_LOAD) begin
                            // abandon the encode; this pixel lands at entry 0
                            o_cmd.load_clr = 1'b1;
                            o_cmd.sp_clr   = 1'b1;
                        end
                        n_ph = P_LOAD;
                    end else if (r_ph == P_LOAD) begin
                        o_cmd.sp_clr = 1'b1;
                        n_ph = P_ENC;
                        n_st = S_SPLIT;     // reused: push root then pop
                        n_leaf = 1'b0;
                    end else if (r_ph == P_ENC) begin
                        if (i_sts.stack_empty) n_ph = P_DONE;
                        else n_st = S_POP;
                    end
                end
            end
            S_SPLIT: begin
                if (!r_leaf) begin
                    o_cmd.push_root = 1'b1;
                    n_leaf = 1'b1;
                    n_st = S_TOP;
                end else begin
                    o_cmd.split = 1'b1;
                    if (i_sts.split_done) begin
                        n_st = S_IDLE;
                        o_tok_load = 1'b1;
                        o_tok_leaf = 1'b0;
                    end
                end
            end
            S_TOP: begin
                n_st = S_POP;           // stack top read catches the root push
            end
            S_POP: begin
                o_cmd.pop = 1'b1;
                n_st = S_LATCH;
            end
            S_LATCH: begin
                o_cmd.scan_init = 1'b1;
                n_st = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.rd_issue = 1'b1;
                n_rdv = 1'b1;
                if (i_sts.mismatch || i_sts.scan_last) n_st = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_rdv) begin
                    if (i_sts.mismatch) begin
                        n_leaf = 1'b1;
                        n_st = S_SPLIT;
                    end else begin
                        o_tok_load = 1'b1;
                        o_tok_leaf = 1'b1;
                        if (i_sts.stack_empty) n_ph = P_DONE;
                        n_st = S_IDLE;
                    end
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ph <= P_LOAD;
            r_rdv <= 1'b0;
            r_leaf <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ph <= n_ph;
            r_rdv <= n_rdv;
            r_leaf <= n_leaf;
        end
    end
endmodule

FILE: hdl/quadtree_image_encoder_unit.sv
// Top level: quadtree image encoder with config port, controller and datapath.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-------------------------------
//  cfg     | in  | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//  in      | in  | i_in_valid/o_in_ready   | i_operation, i_pixel
//  out     | out | o_out_valid/i_out_ready | o_leaf_flag, o_color, o_last_token
//
// A token request pops a region, latches it, scans it and registers its token;
// the scan issues pixel memory reads (one per cycle, stopping one read past
// the first pixel that differs). The first request of an image pushes the
// whole image before its pop, and a split pushes up to four quadrants.
// Reset is synchronous, active low; the pixel memory is not cleared.
// Input is held off while a token waits in the output register.
`include "quadtree_image_encoder_unit_assert.svh"
module quadtree_image_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_operation,
    input  logic [15:0] i_pixel,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_leaf_flag,
    output logic [9:0]  o_color,
    output logic        o_last_token
);
    logic [qie_pkg::CfgW-1:0]      r_w, r_h;
    logic [qie_pkg::SideW-1:0]     w_img, h_img;
    qie_pkg::t_cmd                 cmd;
    qie_pkg::t_sts                 sts;
    logic                          rd_vld, tok_load, tok_leaf, in_fire;
    logic [qie_pkg::ColorBits-1:0] ref_color;
    logic                          r_ovld;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= qie_pkg::CfgW'(512);
            r_h <= qie_pkg::CfgW'(512);
        end else if (i_cfg_valid) begin
            if (i_cfg_index == qie_pkg::RegWidth) r_w <= i_cfg_data;
            else r_h <= i_cfg_data;
        end
    end

    // clamp to 1..MaxSide
    assign w_img = (r_w == '0) ? qie_pkg::SideW'(1) :
                   (r_w > qie_pkg::CfgW'(qie_pkg::MaxSide)) ?
                   qie_pkg::SideW'(qie_pkg::MaxSide) : qie_pkg::SideW'(r_w);
    assign h_img = (r_h == '0) ? qie_pkg::SideW'(1) :
                   (r_h > qie_pkg::CfgW'(qie_pkg::MaxSide)) ?
                   qie_pkg::SideW'(qie_pkg::MaxSide) : qie_pkg::SideW'(r_h);

    assign in_fire = i_in_valid && o_in_ready;

    qie_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_fire(in_fire), .i_op(i_operation), .i_sts(sts),
        .i_out_free(!r_ovld), .o_in_ready, .o_cmd(cmd), .o_rd_vld(rd_vld),
        .o_tok_load(tok_load), .o_tok_leaf(tok_leaf)
    );

    qie_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_pixel, .i_w_img(w_img), .i_h_img(h_img),
        .i_rd_vld(rd_vld), .o_sts(sts), .o_ref_color(ref_color)
    );

    // output register; last flag sampled after the split pushes land
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (tok_load) r_ovld <= 1'b1;
        else if (i_out_ready) r_ovld <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (tok_load) begin
            o_leaf_flag  <= tok_leaf;
            o_color      <= tok_leaf ? ref_color : '0;
            o_last_token <= tok_leaf && sts.stack_empty;
        end
    end
    assign o_out_valid = r_ovld;

    `QIE_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, o_out_valid, !o_in_ready,
        "input accepted while token pending")
    `QIE_ASSERT_NEXT(a_tok_sets_valid, i_clk, i_rst_n, tok_load, o_out_valid,
        "token not registered")
    `QIE_ASSERT_IMP(a_split_zero_color, i_clk, i_rst_n, o_out_valid && !o_leaf_flag,
        o_color == '0 && !o_last_token, "split token carries colour or last")
endmodule
